/* src/great_circle_distance_assert.svh */
// assertion macros for the great-circle distance checker
// used by gcd_checker.sv, no other dependencies
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define GCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define GCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gcd_pkg.sv */
// shared constants, types and functions of the great-circle distance block
// no dependencies
`default_nettype none
package gcd_pkg;

  localparam int CordicStepsDef   = 24;
  localparam int AngleFracBitsDef = 23;

  localparam logic [22:0] RadiusReset = 23'd6371008;
  localparam logic [28:0] DistMax     = 29'd321699088;
  localparam logic [31:0] Deg2RadQ32  = 32'd74961321;
  localparam logic [31:0] GainQ30     = 32'd652032875;
  localparam logic [31:0] HalfPiQ30   = 32'd1686629713;
  localparam logic [31:0] OneQ30      = 32'd1073741824;

  // cordic micro-rotation angle, q30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0: v = 32'd843314857;
        1: v = 32'd497837830;
        2: v = 32'd263043837;
        3: v = 32'd133525159;
        4: v = 32'd67021687;
        5: v = 32'd33543516;
        6: v = 32'd16775851;
        7: v = 32'd8388437;
        8: v = 32'd4194283;
        9: v = 32'd2097149;
        default: v = (i > 30) ? 32'd0 : (32'd1 << (30 - i));
      endcase
      return v;
    end
  endfunction

  // control bits carried down the pipeline beside the data
  typedef struct packed {
    logic vld;
  } gcd_ctl_t;

endpackage
`default_nettype wire

/* src/gcd_cos.sv */
// pipelined cosine of an angle in scaled degrees: range reduction then
// rotation-mode cordic, one step per stage; uses gcd_pkg
`default_nettype none
module gcd_cos
  import gcd_pkg::*;
#(
  parameter int CORDIC_STEPS    = CordicStepsDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  wire               clk,
  input  wire               en,
  input  wire signed [33:0] deg_in,
  output logic signed [33:0] cos_out
);
  localparam logic [33:0] Full    = 34'(360) << ANGLE_FRAC_BITS;
  localparam logic [33:0] Half    = 34'(180) << ANGLE_FRAC_BITS;
  localparam logic [33:0] Quarter = 34'(90) << ANGLE_FRAC_BITS;
  localparam int Sh = ANGLE_FRAC_BITS + 2;

  // stage 0: magnitude and modulo 360 (value below 2^33, quotient small)
  logic [33:0] mag;
  logic [33:0] m0_r, m0_nxt;
  logic [33:0] m1_r;
  logic        neg1_r;
  logic [33:0] m1_nxt;
  logic        neg1_nxt;
  logic [33:0] r_r;
  logic        negr_r;
  logic [63:0] prod;
  logic signed [33:0] x_r [CORDIC_STEPS+1];
  logic signed [33:0] y_r [CORDIC_STEPS+1];
  logic signed [33:0] z_r [CORDIC_STEPS+1];
  logic        neg_r [CORDIC_STEPS+1];

  assign mag = deg_in[33] ? 34'(-deg_in) : 34'(deg_in);

  // modulo by constant: reciprocal estimate of the quotient (at most one low),
  // then one conditional subtract in the next stage
  always_comb begin
    logic [33:0] q;
    q = 34'((64'(mag) * 64'(((64'd1 << 40) / 64'(Full)))) >> 40);
    m0_nxt = 34'(mag - 34'(64'(q) * 64'(Full)));
  end

  always_comb begin
    logic [33:0] m;
    m = (m0_r >= Full) ? m0_r - Full : m0_r;
    if (m > Half) m = Full - m;
    neg1_nxt = 1'b0;
    if (m > Quarter) begin
      m = Half - m;
      neg1_nxt = 1'b1;
    end
    m1_nxt = m;
  end

  assign prod = 64'(m1_r) * 64'(Deg2RadQ32) + (64'd1 << (Sh - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r   <= m0_nxt;
      m1_r   <= m1_nxt;
      neg1_r <= neg1_nxt;
      r_r    <= 34'(prod >> Sh);
      negr_r <= neg1_r;
    end
  end

  always_comb begin
    x_r[0] = 34'(GainQ30);
    y_r[0] = '0;
    z_r[0] = signed'(r_r);
    neg_r[0] = negr_r;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - signed'(34'(atan_q30(i)));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + signed'(34'(atan_q30(i)));
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // output register after m0_r, m1_r, r_r and the cordic steps, all moving with en
  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    end
  end
endmodule
`default_nettype wire

/* src/great_circle_distance.sv */
// great-circle distance top level: haversine datapath, sqrt and vectoring cordic
// uses gcd_pkg and gcd_cos
//
// usage:
//  in_ channel: one point pair (lon_a, lat_a, lon_b, lat_b, degrees * 2^23) per
//  transfer, taken when in_valid is high and in_stall low
//  out_ channel: distance in 1/16 m per transfer, taken when out_valid high
//  and out_stall low
//  cfg_ channel: earth radius in metres, written when cfg_valid and cfg_ready;
//  cfg_ready is always high, write only while the block is idle
//  throughput: one pair per cycle while the output is not stalled; the whole pipeline advances together, so
//  a stall of the output freezes every stage and nothing is lost or repeated
//  stages in order: input register, cosines, haversine, root (one bit per
//  stage), angle cordic and scale
//  in_stall follows out_stall only when the last stage holds a result
//  reset clears every valid bit and loads the default radius
`default_nettype none
module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int CORDIC_STEPS    = CordicStepsDef,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [31:0] in_lon_a,
  input  wire signed [30:0] in_lat_a,
  input  wire signed [31:0] in_lon_b,
  input  wire signed [30:0] in_lat_b,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [28:0]       out_distance_sixteenths,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [22:0]        cfg_earth_radius_m
);
  localparam int CosLat = CORDIC_STEPS + 4;
  localparam int Total  = 1 + CosLat + 3 + 32 + CORDIC_STEPS + 3;

  logic [22:0] radius_r;
  logic        en;
  gcd_ctl_t    ctl_r [Total];

  // whole pipeline moves when the output slot is free or being taken
  assign en        = !(ctl_r[Total-1].vld && out_stall);
  assign in_stall  = !en;
  assign out_valid = ctl_r[Total-1].vld;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RadiusReset;
    end else if (cfg_valid) begin
      radius_r <= cfg_earth_radius_m;
    end
  end

  for (genvar k = 0; k < Total; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].vld <= 1'b0;
      end else if (en) begin
        ctl_r[k].vld <= (k == 0) ? in_valid : ctl_r[(k == 0) ? 0 : k-1].vld;
      end
    end
  end

  // four cosines in parallel
  logic signed [33:0] dlat_r, dlon_r, la_r, lb_r;
  logic signed [33:0] c_dlat, c_dlon, c_la, c_lb;
  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= 34'(in_lat_b) - 34'(in_lat_a);
      dlon_r <= 34'(in_lon_b) - 34'(in_lon_a);
      la_r   <= 34'(in_lat_a);
      lb_r   <= 34'(in_lat_b);
    end
  end
  gcd_cos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
    u_cos0 (.clk(clk), .en(en), .deg_in(dlat_r), .cos_out(c_dlat));
  gcd_cos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
    u_cos1 (.clk(clk), .en(en), .deg_in(dlon_r), .cos_out(c_dlon));
  gcd_cos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
    u_cos2 (.clk(clk), .en(en), .deg_in(la_r), .cos_out(c_la));
  gcd_cos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
    u_cos3 (.clk(clk), .en(en), .deg_in(lb_r), .cos_out(c_lb));

  // haversine: products then sum and clamp
  logic signed [35:0] s1_r, s2_r, p30_r;
  logic signed [67:0] p_r, t2_r;
  logic [62:0]        a62_r;
  logic signed [35:0] s2d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= 36'(signed'(OneQ30)) - 36'(c_dlat);
      s2_r  <= 36'(signed'(OneQ30)) - 36'(c_dlon);
      p_r   <= 68'(c_la) * 68'(c_lb);
      p30_r <= 36'((p_r + (68'sd1 <<< 29)) >>> 30);
      s2d_r <= s2_r;
      t2_r  <= (68'(s1_r) <<< 30);
    end
  end
  logic signed [67:0] a61;
  always_comb a61 = t2_r + 68'(p30_r) * 68'(s2d_r);
  always_ff @(posedge clk) begin
    if (en) begin
      if (a61 < 0) a62_r <= '0;
      else if (a61 > (68'sd1 <<< 61)) a62_r <= 63'd1 << 62;
      else a62_r <= 63'(a61) << 1;
    end
  end

  // two square roots, one result bit per stage
  logic [63:0] va_r [33];
  logic [31:0] ra_r [33];
  logic [63:0] vb_r [33];
  logic [31:0] rb_r [33];
  always_comb begin
    va_r[0] = 64'(a62_r);
    ra_r[0] = '0;
    vb_r[0] = (64'd1 << 62) - 64'(a62_r);
    rb_r[0] = '0;
  end
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int B = 31 - j;
    always_ff @(posedge clk) begin
      logic [63:0] ta, tb;
      ta = 64'(ra_r[j] | (32'd1 << B)) * 64'(ra_r[j] | (32'd1 << B));
      tb = 64'(rb_r[j] | (32'd1 << B)) * 64'(rb_r[j] | (32'd1 << B));
      if (en) begin
        va_r[j+1] <= va_r[j];
        vb_r[j+1] <= vb_r[j];
        ra_r[j+1] <= (ta <= va_r[j]) ? (ra_r[j] | (32'd1 << B)) : ra_r[j];
        rb_r[j+1] <= (tb <= vb_r[j]) ? (rb_r[j] | (32'd1 << B)) : rb_r[j];
      end
    end
  end

  // vectoring cordic for the half central angle
  logic signed [35:0] vx_r [CORDIC_STEPS+1];
  logic signed [35:0] vy_r [CORDIC_STEPS+1];
  logic signed [33:0] vz_r [CORDIC_STEPS+1];
  always_comb begin
    vx_r[0] = 36'(rb_r[32]);
    vy_r[0] = 36'(ra_r[32]);
    vz_r[0] = '0;
  end
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][35]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + signed'(34'(atan_q30(i)));
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - signed'(34'(atan_q30(i)));
        end
      end
    end
  end

  // clamp, scale by radius, saturate
  logic [30:0] zc_r;
  logic [53:0] d_r;
  logic [28:0] dist_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (vz_r[CORDIC_STEPS] < 0) zc_r <= '0;
      else if (vz_r[CORDIC_STEPS] > signed'(34'(HalfPiQ30))) zc_r <= 31'(HalfPiQ30);
      else zc_r <= 31'(vz_r[CORDIC_STEPS]);
      d_r <= (54'(radius_r) * 54'(zc_r) + (54'd1 << 24)) >> 25;
      dist_r <= (d_r > 54'(DistMax)) ? DistMax : 29'(d_r);
    end
  end
  assign out_distance_sixteenths = dist_r;
endmodule
`default_nettype wire

/* src/gcd_checker.sv */
// port-level checker for the great-circle distance block, bound to the top
// uses great_circle_distance_assert.svh
`default_nettype none
`include "great_circle_distance_assert.svh"
module gcd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire        cfg_ready,
  input wire [28:0] out_distance_sixteenths
);
  `GCD_ASSERT_IMPL(a_range, clk, rst_n, out_valid, out_distance_sixteenths <= 29'd321699088, "distance over max")
  `GCD_ASSERT_IMPL(a_nostall, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")
  `GCD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_distance_sixteenths), "stalled result changed")
  `GCD_ASSERT_IMPL(a_cfg, clk, rst_n, 1'b1, cfg_ready, "cfg not ready")
endmodule
bind great_circle_distance gcd_checker u_gcd_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .cfg_ready(cfg_ready),
  .out_distance_sixteenths(out_distance_sixteenths)
);
`default_nettype wire
